### rtl/core/tmf_pkg.sv
package tmf_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] REQ_CLEAR  = 3'd0;
    localparam logic [2:0] REQ_LOAD   = 3'd1;
    localparam logic [2:0] REQ_BEGIN  = 3'd2;
    localparam logic [2:0] REQ_HEADER = 3'd3;
    localparam logic [2:0] REQ_RECORD = 3'd4;

    localparam logic [1:0] V_SKIP = 2'd0;
    localparam logic [1:0] V_KEEP = 2'd1;
    localparam logic [1:0] V_STOP = 2'd2;

    localparam logic [63:0] MAX_VERSION_RST = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [63:0]        super_id;
        logic [63:0]        table_id;
        logic [63:0]        max_super_id;
        logic [63:0]        max_table_id;
        logic signed [63:0] del_version;
        logic signed [63:0] start_key;
        logic signed [63:0] end_key;
    } t_req;

    typedef struct packed {
        logic [1:0]         verdict;
        logic [9:0]         table_index;
        logic signed [63:0] kept_version;
        logic signed [63:0] kept_start_key;
        logic signed [63:0] kept_end_key;
    } t_res;

    typedef struct packed {
        logic [63:0]        target_super_id;
        logic signed [63:0] max_version;
    } t_cfg;

endpackage

### rtl/core/tmf_ram.sv
module tmf_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/tmf_core.sv
module tmf_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  tmf_pkg::t_req i_req,
    input  tmf_pkg::t_cfg i_cfg,
    output logic          o_busy,
    output logic          o_done,
    output tmf_pkg::t_res o_res
);
    import tmf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;

    logic [1:0]       r_state, n_state;
    t_req             r_req;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_cursor, n_cursor;
    logic             r_stopped, n_stopped;
    logic [63:0]      r_first, n_first;
    logic [63:0]      r_last, n_last;
    logic             r_done, n_done;
    t_res             r_res, n_res;

    logic             we;
    logic [IDX_W-1:0] raddr;
    logic [63:0]      rdata;

    logic             live;
    logic [CNT_W-1:0] cur_inc;
    logic [63:0]      cur_wide;
    logic             step;
    logic             finish;
    logic             keep;
    logic [1:0]       verdict;
    logic [63:0]      tgt;

    tmf_ram #(
        .DEPTH(TABLE_DEPTH),
        .WIDTH(64)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_count[IDX_W-1:0]),
        .i_wdata(r_req.table_id),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign tgt      = i_cfg.target_super_id;
    assign live     = !r_stopped && (r_cursor < r_count);
    assign cur_inc  = r_cursor + CNT_W'(1);
    assign cur_wide = 64'(r_cursor);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_stopped = r_stopped;
        n_first   = r_first;
        n_last    = r_last;
        we        = 1'b0;
        raddr     = r_cursor[IDX_W-1:0];
        step      = 1'b0;
        finish    = 1'b0;
        keep      = 1'b0;
        verdict   = V_SKIP;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                finish = 1'b1;
                unique case (r_req.req_type)
                    REQ_CLEAR: begin
                        n_count   = '0;
                        n_cursor  = '0;
                        n_stopped = 1'b0;
                    end
                    REQ_LOAD: begin
                        if (r_count < CNT_W'(TABLE_DEPTH)) begin
                            we      = 1'b1;
                            n_count = r_count + CNT_W'(1);
                            n_last  = r_req.table_id;
                            if (r_count == '0) begin
                                n_first = r_req.table_id;
                            end
                        end
                    end
                    REQ_BEGIN: begin
                        n_cursor  = '0;
                        n_stopped = 1'b0;
                    end
                    REQ_HEADER: begin
                        if (!live) begin
                            verdict = V_STOP;
                        end else if (r_req.max_super_id < tgt) begin
                            verdict = V_SKIP;
                        end else if (r_req.super_id > tgt) begin
                            verdict = V_STOP;
                        end else if (r_req.max_super_id == tgt &&
                                     r_req.max_table_id < r_first) begin
                            verdict = V_SKIP;
                        end else if (r_req.super_id == tgt &&
                                     r_req.table_id > r_last) begin
                            verdict = V_STOP;
                        end else begin
                            verdict = V_KEEP;
                        end
                    end
                    REQ_RECORD: begin
                        if (!live) begin
                            verdict = V_STOP;
                        end else if (r_req.super_id < tgt) begin
                            verdict = V_SKIP;
                        end else if (r_req.super_id > tgt) begin
                            verdict = V_STOP;
                        end else begin
                            step   = 1'b1;
                            finish = 1'b0;
                        end
                    end
                    default: begin
                        verdict = V_SKIP;
                    end
                endcase
            end
            ST_WALK: begin
                step = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // merge step: table entry at the cursor is on the read port
        if (step) begin
            if (rdata < r_req.table_id) begin
                n_cursor = cur_inc;
                if (cur_inc >= r_count) begin
                    finish  = 1'b1;
                    verdict = V_STOP;
                end else begin
                    raddr   = cur_inc[IDX_W-1:0];
                    n_state = ST_WALK;
                end
            end else begin
                finish = 1'b1;
                if (r_req.table_id < rdata) begin
                    verdict = V_SKIP;
                end else if (r_req.del_version <= i_cfg.max_version) begin
                    verdict = V_KEEP;
                    keep    = 1'b1;
                end else begin
                    verdict = V_SKIP;
                end
            end
        end

        if (finish) begin
            n_state = ST_IDLE;
            if (verdict == V_STOP) begin
                n_stopped = 1'b1;
            end
        end
    end

    always_comb begin
        n_done              = finish;
        n_res.verdict       = verdict;
        n_res.table_index   = keep ? cur_wide[9:0] : 10'd0;
        n_res.kept_version   = keep ? r_req.del_version : 64'sd0;
        n_res.kept_start_key = keep ? r_req.start_key : 64'sd0;
        n_res.kept_end_key   = keep ? r_req.end_key : 64'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_cursor  <= '0;
            r_stopped <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cursor  <= n_cursor;
            r_stopped <= n_stopped;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_req <= i_req;
        end
        r_first <= n_first;
        r_last  <= n_last;
        r_res   <= n_res;
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

### rtl/core/tombstone_merge_filter_top.sv
// table commands, headers and records that match or miss at the cursor run in the EXEC
// state, with the result strobe registered from it; each cursor advance of a record
// inside the table passes through the WALK state; one past the end does not
// a new item is taken only while busy is low; the merge walk steps one entry a cycle
// through the single read port of the id table memory
// reset: synchronous active low; clears table count, cursor, stop flag, state and done
module tombstone_merge_filter_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  tmf_pkg::t_req i_req,
    output logic          o_done,
    output tmf_pkg::t_res o_res,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);
    import tmf_pkg::*;

    t_cfg r_cfg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_super_id <= '0;
            r_cfg.max_version     <= MAX_VERSION_RST;
        end else if (cfg_wr) begin
            if (paddr[3]) begin
                r_cfg.max_version <= pwdata;
            end else begin
                r_cfg.target_super_id <= pwdata;
            end
        end
    end

    assign prdata = paddr[3] ? r_cfg.max_version : r_cfg.target_super_id;

    tmf_core u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_req  (i_req),
        .i_cfg  (r_cfg),
        .o_busy (busy),
        .o_done (o_done),
        .o_res  (o_res)
    );

endmodule

### rtl/core/tmf_checker.sv
module tmf_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input tmf_pkg::t_res o_res
);
    import tmf_pkg::*;

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after transfer");

    a_no_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !o_done)
        else $error("result one cycle after transfer");

    a_idle_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("busy while result shown");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.verdict == V_SKIP || o_res.verdict == V_KEEP ||
                    o_res.verdict == V_STOP))
        else $error("bad verdict code");

    a_clear_unless_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.verdict != V_KEEP |->
            o_res.table_index == 10'd0 && o_res.kept_version == 64'sd0 &&
            o_res.kept_start_key == 64'sd0 && o_res.kept_end_key == 64'sd0)
        else $error("payload set without keep");

endmodule

bind tombstone_merge_filter_top tmf_checker u_tmf_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .o_done (o_done),
    .o_res  (o_res)
);
